// ===== design/glpf_pkg.sv =====
// Shared types and constants for the grid local peak finder.
// Used by glpf_cell, glpf_emit and grid_local_peak_finder_unit; no dependencies.
package glpf_pkg;

  // Fixed field widths of the ports
  localparam int SAMPLE_W   = 32;
  localparam int ROW_W      = 16;
  localparam int OUT_COL_W  = 5;
  localparam int CFG_COLS_W = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Defaults for the module parameters
  localparam int MAX_COLS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int COL_W_DEF       = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 4'd0,
    REG_GRID_COLS = 4'd1
  } cfg_reg_t;

  // Per-item control broadcast to every cell
  typedef struct packed {
    logic accept;
    logic bank;
    logic row_ge1;
    logic row_ge2;
    logic last_col;
    logic last_row;
  } cell_ctl_t;

  // What a cell reports back for the item at hand
  typedef struct packed {
    logic dec_hit;
    logic burst_bit;
  } cell_stat_t;

  // Result set handed to the emitter on an accepted item
  typedef struct packed {
    logic             load;
    logic             dec_hit;
    logic [ROW_W-1:0] dec_row;
    logic [ROW_W-1:0] burst_row;
  } emit_load_t;

endpackage

// ===== design/grid_local_peak_finder_unit.sv =====
// Top level of the grid local peak finder: counters, config registers, the row
// of column cells and the result emitter. Depends on glpf_pkg, glpf_cell, glpf_emit.
//
// Usage:
//   Write grid_rows (index 0) and grid_cols (index 1) on the cfg channel
//   (cfg_ready is always high). Then stream samples in raster order on the in
//   channel (in_valid / in_stall). Peaks come out on the out channel as
//   (row, col) items in raster order; out_run_last marks the last item caused
//   by one sample.
// Latency: a cell is decided when the sample below it arrives, i.e. one grid
//   row later; its item appears on out the cycle after that sample is taken.
//   Last-row peaks are released as a burst after the final sample of a grid.
// Throughput: one sample per cycle while in_stall is low. The emitter holds
//   one sample's results; the final sample of a grid occupies it for its
//   decided peak and the flag walk, and in_stall is high meanwhile.
// Stall: while out_stall is high the held item stays on out and in_stall
//   stays high unless the emitter is empty.
// Reset: rst_n (synchronous) returns counters, flags and config to reset
//   values (grid_rows = 1, grid_cols = 32); line entries are not cleared.
module grid_local_peak_finder_unit #(
  parameter int MAX_COLS    = glpf_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = glpf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [glpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glpf_pkg::CFG_DATA_W-1:0]     cfg_data,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [glpf_pkg::SAMPLE_W-1:0] in_sample,
  // peak channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [glpf_pkg::ROW_W-1:0]          out_peak_row,
  output logic [glpf_pkg::OUT_COL_W-1:0]      out_peak_col,
  output logic                                out_run_last
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = glpf_pkg::ROW_W;
  localparam int CC_W  = glpf_pkg::CFG_COLS_W;

  logic [ROW_W-1:0]  grid_rows_r, grid_rows_nxt;
  logic [CC_W-1:0]   grid_cols_r, grid_cols_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              bank_r, bank_nxt;

  logic [CC_W-1:0]   cols_eff;
  logic [ROW_W-1:0]  rows_eff;
  logic              accept, last_col, last_row, emit_free;
  logic signed [SAMPLE_BITS-1:0] x;

  glpf_pkg::cell_ctl_t  ctl;
  glpf_pkg::cell_stat_t stat_v [MAX_COLS];
  glpf_pkg::emit_load_t load;

  logic signed [SAMPLE_BITS-1:0] mid_v   [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] up_v    [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] mid_l_v [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] mid_r_v [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] up_l_v  [MAX_COLS];
  logic [MAX_COLS-1:0] hit_vec, burst_vec, flags_out;

  // Config port: always ready
  assign cfg_ready = 1'b1;

  always_comb begin
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        glpf_pkg::REG_GRID_ROWS: grid_rows_nxt = cfg_data;
        glpf_pkg::REG_GRID_COLS: grid_cols_nxt = cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to what the hardware can hold
  always_comb begin
    if (grid_cols_r == '0)                   cols_eff = CC_W'(1);
    else if (grid_cols_r > CC_W'(MAX_COLS))  cols_eff = CC_W'(MAX_COLS);
    else                                     cols_eff = grid_cols_r;
    rows_eff = (grid_rows_r == '0) ? ROW_W'(1) : grid_rows_r;
  end

  assign x        = in_sample[SAMPLE_BITS-1:0];
  assign accept   = in_valid & ~in_stall;
  assign in_stall = ~emit_free;
  assign last_col = (({1'b0, col_r} + (COL_W+1)'(1)) >= (COL_W+1)'(cols_eff));
  assign last_row = (({1'b0, row_r} + (ROW_W+1)'(1)) >= {1'b0, rows_eff});

  assign ctl.accept   = accept;
  assign ctl.bank     = bank_r;
  assign ctl.row_ge1  = (row_r != '0);
  assign ctl.row_ge2  = (row_r > ROW_W'(1));
  assign ctl.last_col = last_col;
  assign ctl.last_row = last_row;

  // Position counters and bank swap at the end of each row but the grid's last
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    bank_nxt = bank_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          bank_nxt = ~bank_r;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= ROW_W'(1);
      grid_cols_r <= CC_W'(32);
      col_r       <= '0;
      row_r       <= '0;
      bank_r      <= 1'b0;
    end else begin
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      bank_r      <= bank_nxt;
    end
  end

  // Row of column cells, each wired to its left and right neighbour
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign mid_l_v[i] = '0;
      assign up_l_v[i]  = '0;
    end else begin : g_inner
      assign mid_l_v[i] = mid_v[i-1];
      assign up_l_v[i]  = up_v[i-1];
    end
    if (i == MAX_COLS - 1) begin : g_last
      assign mid_r_v[i] = '0;
    end else begin : g_body
      assign mid_r_v[i] = mid_v[i+1];
    end

    glpf_cell #(
      .IDX         (i),
      .COL_W       (COL_W),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .col_i       (col_r),
      .cols_i      (cols_eff),
      .x_i         (x),
      .mid_left_i  (mid_l_v[i]),
      .mid_right_i (mid_r_v[i]),
      .up_left_i   (up_l_v[i]),
      .mid_o       (mid_v[i]),
      .up_o        (up_v[i]),
      .stat_o      (stat_v[i])
    );

    assign hit_vec[i]   = stat_v[i].dec_hit;
    assign burst_vec[i] = stat_v[i].burst_bit;
  end

  // Burst only on the final sample of the grid
  assign flags_out = (last_col && last_row) ? burst_vec : '0;

  assign load.load      = accept;
  assign load.dec_hit   = |hit_vec;
  assign load.dec_row   = row_r - 1'b1;
  assign load.burst_row = row_r;

  glpf_emit #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .dec_col_i   (col_r),
    .flags_i     (flags_out),
    .out_stall_i (out_stall),
    .out_valid_o (out_valid),
    .peak_row_o  (out_peak_row),
    .peak_col_o  (out_peak_col),
    .run_last_o  (out_run_last),
    .free_o      (emit_free)
  );

endmodule

// ===== design/glpf_cell.sv =====
// One column cell: two line entries (bank swapped), the column's last-row flag
// and the local 4-neighbour compares. Depends on glpf_pkg.
module glpf_cell #(
  parameter int IDX         = 0,
  parameter int COL_W       = glpf_pkg::COL_W_DEF,
  parameter int SAMPLE_BITS = glpf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  glpf_pkg::cell_ctl_t                 ctl_i,
  input  logic [COL_W-1:0]                    col_i,
  input  logic [glpf_pkg::CFG_COLS_W-1:0]     cols_i,
  input  logic signed [SAMPLE_BITS-1:0]       x_i,
  input  logic signed [SAMPLE_BITS-1:0]       mid_left_i,
  input  logic signed [SAMPLE_BITS-1:0]       mid_right_i,
  input  logic signed [SAMPLE_BITS-1:0]       up_left_i,
  output logic signed [SAMPLE_BITS-1:0]       mid_o,
  output logic signed [SAMPLE_BITS-1:0]       up_o,
  output glpf_pkg::cell_stat_t                stat_o
);

  localparam bit HAS_LEFT = (IDX > 0);

  logic signed [SAMPLE_BITS-1:0] a_r, b_r;
  logic signed [SAMPLE_BITS-1:0] mid, up;
  logic                          flag_r, flag_nxt;
  logic                          sel, sel_right;
  logic                          ok, cand, clr, flag_upd;

  // bank picks which entry is the middle row and which the upper row
  assign mid   = ctl_i.bank ? b_r : a_r;
  assign up    = ctl_i.bank ? a_r : b_r;
  assign mid_o = mid;
  assign up_o  = up;

  assign sel       = (col_i == COL_W'(IDX));
  assign sel_right = ({1'b0, col_i} == (COL_W+1)'(IDX + 1));

  // Decide the cell one row above the arriving sample
  always_comb begin
    ok = (mid >= x_i);
    if (ctl_i.row_ge2 && (mid < up)) ok = 1'b0;
    if (HAS_LEFT && (mid < mid_left_i)) ok = 1'b0;
    if (!ctl_i.last_col && (mid < mid_right_i)) ok = 1'b0;
  end

  // Last-row candidate from its up and left neighbours
  always_comb begin
    cand = ctl_i.last_row;
    if (ctl_i.row_ge1 && (x_i < mid)) cand = 1'b0;
    if (HAS_LEFT && (x_i < up_left_i)) cand = 1'b0;
  end

  // Right neighbour of the last row beats this column
  assign clr      = sel_right & ctl_i.last_row & (x_i > up);
  assign flag_upd = (flag_r & ~clr) | (sel & cand);

  always_comb begin
    flag_nxt = flag_r;
    if (ctl_i.accept) begin
      flag_nxt = ctl_i.last_col ? 1'b0 : flag_upd;
    end
  end

  assign stat_o.dec_hit   = sel & ctl_i.row_ge1 & ok;
  assign stat_o.burst_bit = flag_upd & (cols_i > glpf_pkg::CFG_COLS_W'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  // Arriving sample goes into the upper-row entry of its column
  always_ff @(posedge clk) begin
    if (ctl_i.accept && sel) begin
      if (ctl_i.bank) a_r <= x_i;
      else            b_r <= x_i;
    end
  end

endmodule

// ===== design/glpf_emit.sv =====
// Result emitter: holds one item's results (a decided peak, then a walk over the
// last-row flags) and feeds the out channel. Depends on glpf_pkg.
module glpf_emit #(
  parameter int MAX_COLS = glpf_pkg::MAX_COLS_DEF,
  parameter int COL_W    = glpf_pkg::COL_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  glpf_pkg::emit_load_t               load_i,
  input  logic [COL_W-1:0]                   dec_col_i,
  input  logic [MAX_COLS-1:0]                flags_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [glpf_pkg::ROW_W-1:0]         peak_row_o,
  output logic [glpf_pkg::OUT_COL_W-1:0]     peak_col_o,
  output logic                               run_last_o,
  output logic                               free_o
);

  logic                        dec_v_r, dec_v_nxt;
  logic [glpf_pkg::ROW_W-1:0]  dec_row_r, dec_row_nxt;
  logic [COL_W-1:0]            dec_col_r, dec_col_nxt;
  logic [MAX_COLS-1:0]         flags_r, flags_nxt;
  logic [glpf_pkg::ROW_W-1:0]  brow_r, brow_nxt;
  logic [COL_W-1:0]            bcol_r, bcol_nxt;
  logic                        taken, empty, rest_zero, last_now;

  assign rest_zero = ((flags_r >> 1) == '0);
  assign empty     = !dec_v_r && (flags_r == '0);
  assign last_now  = dec_v_r ? (flags_r == '0) : (flags_r[0] & rest_zero);

  assign out_valid_o = dec_v_r | flags_r[0];
  assign taken       = out_valid_o & ~out_stall_i;
  assign free_o      = empty | (taken & last_now);

  assign peak_row_o = dec_v_r ? dec_row_r : brow_r;
  assign peak_col_o = dec_v_r ? glpf_pkg::OUT_COL_W'(dec_col_r)
                              : glpf_pkg::OUT_COL_W'(bcol_r);
  assign run_last_o = last_now;

  // Decided peak first, then flags lowest column first
  always_comb begin
    dec_v_nxt   = dec_v_r;
    dec_row_nxt = dec_row_r;
    dec_col_nxt = dec_col_r;
    flags_nxt   = flags_r;
    brow_nxt    = brow_r;
    bcol_nxt    = bcol_r;
    if (load_i.load) begin
      dec_v_nxt   = load_i.dec_hit;
      dec_row_nxt = load_i.dec_row;
      dec_col_nxt = dec_col_i;
      flags_nxt   = flags_i;
      brow_nxt    = load_i.burst_row;
      bcol_nxt    = '0;
    end else if (dec_v_r) begin
      if (taken) dec_v_nxt = 1'b0;
    end else if (flags_r != '0) begin
      // step past a clear flag, or past one just delivered
      if (!flags_r[0] || taken) begin
        flags_nxt = flags_r >> 1;
        bcol_nxt  = bcol_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r <= 1'b0;
      flags_r <= '0;
    end else begin
      dec_v_r <= dec_v_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dec_row_r <= dec_row_nxt;
    dec_col_r <= dec_col_nxt;
    brow_r    <= brow_nxt;
    bcol_r    <= bcol_nxt;
  end

endmodule
